// ===== rtl/core/ipt_pkg.sv =====
// ----------------------------------------------------------------------------
// Inverse Park transform package
// Fixed-point formats, the quarter-wave sine ROM contents and the stage
// enable bundle shared by the transform's cells.
// ----------------------------------------------------------------------------
package ipt_pkg;

    localparam int Q_FRAC          = 24;
    localparam int SINE_TABLE_BITS = 10;

    localparam int DATA_W  = 32;
    localparam int ANGLE_W = 24;
    localparam int PHASE_W = 32;

    localparam int TAB_LEN   = (1 << SINE_TABLE_BITS) + 1;
    localparam int ADDR_W    = SINE_TABLE_BITS + 1;
    localparam int FRAC_BITS = 30 - SINE_TABLE_BITS;
    localparam int SIN_W     = Q_FRAC + 1;
    localparam int COEF_W    = Q_FRAC + 2;
    localparam int ROM_W     = 2 * SIN_W;

    localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;

    typedef logic [63:0] t_div_list [8];
    localparam t_div_list TAYLOR_DIV = '{64'd6, 64'd20, 64'd42, 64'd72,
                                         64'd110, 64'd156, 64'd210, 64'd272};

    // Each word holds an entry in the upper half and the clamped step to the
    // next entry in the lower half, so one read serves an interpolation.
    typedef logic [ROM_W-1:0] t_rom [TAB_LEN];

    typedef struct packed {
        logic lookup;
        logic interp;
    } t_interp_en;

    function automatic logic [SIN_W-1:0] sine_entry(input int k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        x    = (64'(k) * HALF_PI_Q31 + (64'd1 << (SINE_TABLE_BITS - 1))) >> SINE_TABLE_BITS;
        x2   = (x * x) >> 31;
        term = x;
        sum  = $signed(x);
        for (int n = 0; n < 8; n++) begin
            term = ((term * x2) >> 31) / TAYLOR_DIV[n];
            if ((n % 2) == 0) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        v = ($unsigned(sum) + (64'd1 << (30 - Q_FRAC))) >> (31 - Q_FRAC);
        if (v > (64'd1 << Q_FRAC)) begin
            v = 64'd1 << Q_FRAC;
        end
        return v[SIN_W-1:0];
    endfunction

    function automatic t_rom build_sine_rom();
        t_rom               rom;
        logic [SIN_W-1:0]   lo;
        logic [SIN_W-1:0]   hi;
        logic [SIN_W-1:0]   step;
        for (int k = 0; k < TAB_LEN; k++) begin
            lo = sine_entry(k);
            if (k < TAB_LEN - 1) begin
                hi = sine_entry(k + 1);
            end else begin
                hi = lo;
            end
            step   = (hi > lo) ? (hi - lo) : '0;
            rom[k] = {lo, step};
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_sine_rom();

endpackage

// ===== rtl/core/ipt_interp.sv =====
// ----------------------------------------------------------------------------
// Quarter-wave sine lookup cell
// Folds a 32-bit phase into the first quadrant, reads the sine ROM and
// interpolates linearly between neighbouring entries over two stages.
// ----------------------------------------------------------------------------
module ipt_interp (
    input  logic                                i_clk,
    input  ipt_pkg::t_interp_en                 i_en,
    input  logic [ipt_pkg::PHASE_W-1:0]         i_phase,
    output logic signed [ipt_pkg::COEF_W-1:0]   o_value
);

    logic [30:0]                       w_u;
    logic [ipt_pkg::ADDR_W-1:0]        w_addr;
    logic [ipt_pkg::ROM_W-1:0]         r_word;
    logic [ipt_pkg::FRAC_BITS-1:0]     r_frac;
    logic                              r_neg;
    logic [ipt_pkg::SIN_W-1:0]         w_lo;
    logic [ipt_pkg::SIN_W-1:0]         w_step;
    logic [ipt_pkg::SIN_W+ipt_pkg::FRAC_BITS-1:0] w_prod;
    logic [ipt_pkg::SIN_W-1:0]         w_mag;
    logic signed [ipt_pkg::COEF_W-1:0] r_value;

    // Odd quadrants read the table mirrored.
    always_comb begin
        if (i_phase[30]) begin
            w_u = 31'h4000_0000 - {1'b0, i_phase[29:0]};
        end else begin
            w_u = {1'b0, i_phase[29:0]};
        end
        w_addr = w_u[30:ipt_pkg::FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.lookup) begin
            r_word <= ipt_pkg::SINE_ROM[w_addr];
            r_frac <= w_u[ipt_pkg::FRAC_BITS-1:0];
            r_neg  <= i_phase[31];
        end
    end

    always_comb begin
        w_lo   = r_word[ipt_pkg::ROM_W-1:ipt_pkg::SIN_W];
        w_step = r_word[ipt_pkg::SIN_W-1:0];
        w_prod = (ipt_pkg::SIN_W + ipt_pkg::FRAC_BITS)'(w_step) *
                 (ipt_pkg::SIN_W + ipt_pkg::FRAC_BITS)'(r_frac);
        w_mag  = w_lo + w_prod[ipt_pkg::SIN_W+ipt_pkg::FRAC_BITS-1:ipt_pkg::FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.interp) begin
            if (r_neg) begin
                r_value <= -$signed({1'b0, w_mag});
            end else begin
                r_value <= $signed({1'b0, w_mag});
            end
        end
    end

    assign o_value = r_value;

endmodule

// ===== rtl/core/ipt_rot_cell.sv =====
// ----------------------------------------------------------------------------
// Rotation cell
// Multiplies two operands by one coefficient, truncates each product to the
// fixed-point format and adds it into the partial sums it passes on (sum a may subtract).
// ----------------------------------------------------------------------------
module ipt_rot_cell (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic                                i_sub_a,
    input  logic signed [ipt_pkg::DATA_W-1:0]   i_x,
    input  logic signed [ipt_pkg::DATA_W-1:0]   i_y,
    input  logic signed [ipt_pkg::COEF_W-1:0]   i_coef,
    input  logic [ipt_pkg::DATA_W-1:0]          i_acc_a,
    input  logic [ipt_pkg::DATA_W-1:0]          i_acc_b,
    output logic [ipt_pkg::DATA_W-1:0]          o_acc_a,
    output logic [ipt_pkg::DATA_W-1:0]          o_acc_b
);

    localparam int PROD_W = ipt_pkg::DATA_W + ipt_pkg::COEF_W;

    logic signed [PROD_W-1:0]         w_prod_a;
    logic signed [PROD_W-1:0]         w_prod_b;
    logic [ipt_pkg::DATA_W-1:0]       w_term_a;
    logic [ipt_pkg::DATA_W-1:0]       w_term_b;
    logic [ipt_pkg::DATA_W-1:0]       r_acc_a;
    logic [ipt_pkg::DATA_W-1:0]       r_acc_b;

    // Taking the bits above the fraction is an arithmetic shift, so products
    // round towards minus infinity and wrap at the data width.
    always_comb begin
        w_prod_a = PROD_W'(i_x) * PROD_W'(i_coef);
        w_prod_b = PROD_W'(i_y) * PROD_W'(i_coef);
        w_term_a = w_prod_a[ipt_pkg::Q_FRAC+ipt_pkg::DATA_W-1:ipt_pkg::Q_FRAC];
        w_term_b = w_prod_b[ipt_pkg::Q_FRAC+ipt_pkg::DATA_W-1:ipt_pkg::Q_FRAC];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_sub_a) begin
                r_acc_a <= i_acc_a - w_term_a;
            end else begin
                r_acc_a <= i_acc_a + w_term_a;
            end
            r_acc_b <= i_acc_b + w_term_b;
        end
    end

    assign o_acc_a = r_acc_a;
    assign o_acc_b = r_acc_b;

endmodule

// ===== rtl/core/inverse_park_transform_unit.sv =====
// ----------------------------------------------------------------------------
// Inverse Park transform unit
// Rotates a (d, q) pair by a per-unit angle into the stationary (alpha, beta)
// frame using interpolated quarter-wave sine and cosine.
// ----------------------------------------------------------------------------
// The unit accepts one request per clock while the output is not stalled;
// each result passes through the sine ROM read (one read port per lookup
// cell), interpolation and the chain of rotation cells, each holding one
// multiplier pair. Every stage holds its own valid bit and moves on as soon
// as the stage after it has room, so gaps in the pipeline let requests in
// while a result waits at the output. The sine ROM that both lookup cells
// read is constant and needs no fill after reset.
module inverse_park_transform_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] d_axis, [63:32] q_axis, [87:64] angle_pu
    input  logic [87:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] alpha_out, [63:32] beta_out
    output logic [63:0]  m_axis_tdata
);

    localparam int W = ipt_pkg::DATA_W;

    logic r_v1, r_v2, r_v3, r_v4;
    logic n_v1, n_v2, n_v3, n_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    logic signed [W-1:0]               w_d_in;
    logic signed [W-1:0]               w_q_in;
    logic [ipt_pkg::PHASE_W+ipt_pkg::ANGLE_W-1:0] w_phase_wide;
    logic [ipt_pkg::PHASE_W-1:0]       w_phase_sin;
    logic [ipt_pkg::PHASE_W-1:0]       w_phase_cos;
    ipt_pkg::t_interp_en               w_interp_en;

    logic signed [W-1:0]               r_d1, r_q1, r_d2, r_q2, r_d3, r_q3;
    logic signed [ipt_pkg::COEF_W-1:0] w_sin;
    logic signed [ipt_pkg::COEF_W-1:0] w_cos;
    logic signed [ipt_pkg::COEF_W-1:0] r_s3;
    logic [W-1:0]                      w_a3, w_b3, w_a4, w_b4;

    assign w_rdy4 = !r_v4 || m_axis_tready;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign s_axis_tready = w_rdy1;

    always_comb begin
        n_v1 = w_rdy1 ? s_axis_tvalid : r_v1;
        n_v2 = w_rdy2 ? r_v1 : r_v2;
        n_v3 = w_rdy3 ? r_v2 : r_v3;
        n_v4 = w_rdy4 ? r_v3 : r_v4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
            r_v4 <= n_v4;
        end
    end

    // The angle is scaled to a full 32-bit turn; cosine leads by a quarter.
    always_comb begin
        w_d_in       = s_axis_tdata[31:0];
        w_q_in       = s_axis_tdata[63:32];
        w_phase_wide = (ipt_pkg::PHASE_W + ipt_pkg::ANGLE_W)'(s_axis_tdata[87:64])
                       << (ipt_pkg::PHASE_W - ipt_pkg::Q_FRAC);
        w_phase_sin  = w_phase_wide[ipt_pkg::PHASE_W-1:0];
        w_phase_cos  = w_phase_sin + 32'h4000_0000;
        w_interp_en.lookup = w_rdy1;
        w_interp_en.interp = w_rdy2;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_d1 <= w_d_in;
            r_q1 <= w_q_in;
        end
        if (w_rdy2) begin
            r_d2 <= r_d1;
            r_q2 <= r_q1;
        end
        if (w_rdy3) begin
            r_d3 <= r_d2;
            r_q3 <= r_q2;
            r_s3 <= w_sin;
        end
    end

    ipt_interp u_sin (
        .i_clk   (i_clk),
        .i_en    (w_interp_en),
        .i_phase (w_phase_sin),
        .o_value (w_sin)
    );

    ipt_interp u_cos (
        .i_clk   (i_clk),
        .i_en    (w_interp_en),
        .i_phase (w_phase_cos),
        .o_value (w_cos)
    );

    // First cell forms d*cos and q*cos; the second folds in the sine terms.
    ipt_rot_cell u_cell_cos (
        .i_clk   (i_clk),
        .i_en    (w_rdy3),
        .i_sub_a (1'b0),
        .i_x     (r_d2),
        .i_y     (r_q2),
        .i_coef  (w_cos),
        .i_acc_a ('0),
        .i_acc_b ('0),
        .o_acc_a (w_a3),
        .o_acc_b (w_b3)
    );

    ipt_rot_cell u_cell_sin (
        .i_clk   (i_clk),
        .i_en    (w_rdy4),
        .i_sub_a (1'b1),
        .i_x     (r_q3),
        .i_y     (r_d3),
        .i_coef  (r_s3),
        .i_acc_a (w_a3),
        .i_acc_b (w_b3),
        .o_acc_a (w_a4),
        .o_acc_b (w_b4)
    );

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {w_b4, w_a4};

endmodule
